FILE: sv/atan2_pkg.sv
// ----------------------------------------------------------------------------
// atan2_pkg: shared widths, constants and types of the arctangent pipeline
// Holds the fixed-point formats of every stage, the polynomial coefficients,
// the folding constants and the sideband struct that follows each item.
// ----------------------------------------------------------------------------
package atan2_pkg;

  // Input and output formats.
  localparam int INPUT_WIDTH         = 16;
  localparam int ANGLE_FRACTION_BITS = 13;
  localparam int ANGLE_WIDTH         = 16;

  // Magnitudes need one bit more than the signed inputs.
  localparam int MAG_W   = INPUT_WIDTH + 1;
  // The ratio is Q0.16 with 1.0 held as 2^16.
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = FRAC_W + 1;
  localparam int NUM_W   = MAG_W + FRAC_W;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;

  // Divider: quotient bits resolved per register stage.
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = (RATIO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  // Polynomial datapath widths; the coefficients and the terms p, q, r and t are at 30 fraction bits.
  localparam int POLY_STAGES = 10;
  localparam int SQ_W  = 2 * RATIO_W;
  localparam int C3_W  = 27;
  localparam int M3_W  = C3_W + RATIO_W + 1;
  localparam int P_W   = 29;
  localparam int M5_W  = P_W + RATIO_W + 1;
  localparam int Q_W   = 30;
  localparam int M7_W  = Q_W + RATIO_W + 1;
  localparam int R_W   = 30;
  localparam int M9_W  = R_W + RATIO_W + 1;
  localparam int T_W   = 32;
  localparam int Q30_SHIFT = 30 - FRAC_W;
  localparam int HALF_LSB  = 1 << (FRAC_W - 1);

  localparam logic signed [C3_W-1:0] COEF_C3 = -C3_W'(49925210);
  localparam logic signed [P_W-1:0]  COEF_C2 = P_W'(171062341);
  localparam logic signed [Q_W-1:0]  COEF_C1 = -Q_W'(351782264);

  // Octant folding and final rounding.
  localparam int FOLD_W = 34;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam logic signed [FOLD_W-1:0] HALF_PI = FOLD_W'(HALF_PI_Q30);
  localparam logic signed [FOLD_W-1:0] PI      = FOLD_W'(PI_Q30);
  localparam int ANGLE_SHIFT = 30 - ANGLE_FRACTION_BITS;
  localparam longint LIMIT_RAW =
    (PI_Q30 + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
  localparam longint ANGLE_MAX = (64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [FOLD_W-1:0] ANGLE_LIMIT =
    FOLD_W'((LIMIT_RAW > ANGLE_MAX) ? ANGLE_MAX : LIMIT_RAW);

  // Per-item sideband that rides along the datapath.
  typedef struct packed {
    logic xneg;   // x is negative
    logic yneg;   // y is negative
    logic swap;   // |y| > |x|
    logic zero;   // input is the origin
  } side_t;

endpackage

FILE: sv/atan2_prep.sv
// ----------------------------------------------------------------------------
// atan2_prep: magnitude and ordering stage
// Takes the coordinate pair apart into signs and magnitudes, orders the
// magnitudes and forms the rounded dividend for the ratio.
// ----------------------------------------------------------------------------
module atan2_prep
  import atan2_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [INPUT_WIDTH-1:0] x_coord_i,
  input  logic signed [INPUT_WIDTH-1:0] y_coord_i,
  output logic                          valid_o,
  output logic        [NUM_W-1:0]       num_o,
  output logic        [MAG_W-1:0]       hi_o,
  output side_t                         side_o
);

  logic [MAG_W-1:0] ax, ay, lo, hi;
  logic             gt;
  side_t            side_d;
  logic [NUM_W-1:0] num_d;

  // Signs, magnitudes and the ordered pair.
  always_comb begin
    side_d.xneg = x_coord_i[INPUT_WIDTH-1];
    side_d.yneg = y_coord_i[INPUT_WIDTH-1];
    ax = side_d.xneg ? (MAG_W'(0) - {x_coord_i[INPUT_WIDTH-1], x_coord_i})
                     : {1'b0, x_coord_i};
    ay = side_d.yneg ? (MAG_W'(0) - {y_coord_i[INPUT_WIDTH-1], y_coord_i})
                     : {1'b0, y_coord_i};
    gt          = ax > ay;
    side_d.swap = ay > ax;
    side_d.zero = (ax == '0) && (ay == '0);
    lo = gt ? ay : ax;
    hi = gt ? ax : ay;
    // Dividend lo * 2^16 plus half the divisor gives a rounded quotient.
    num_d = {lo, {FRAC_W{1'b0}}} + NUM_W'(hi >> 1);
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_o  <= num_d;
      hi_o   <= hi;
      side_o <= side_d;
    end
  end

endmodule

FILE: sv/atan2_div.sv
// ----------------------------------------------------------------------------
// atan2_div: pipelined restoring divider
// Produces the ratio lo / hi as unsigned Q0.16, resolving two quotient bits
// in each register stage but the last, which resolves one.
// ----------------------------------------------------------------------------
module atan2_div
  import atan2_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [MAG_W-1:0]   hi_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [RATIO_W-1:0] ratio_o,
  output side_t              side_o
);

  // Stage registers.
  logic               vld_q  [DIV_STAGES];
  logic [MAG_W-1:0]   rem_q  [DIV_STAGES];
  logic [RATIO_W-1:0] bits_q [DIV_STAGES];
  logic [RATIO_W-1:0] quo_q  [DIV_STAGES];
  logic [MAG_W-1:0]   hi_q   [DIV_STAGES];
  side_t              side_q [DIV_STAGES];

  // Stage inputs and next values.
  logic               vld_in  [DIV_STAGES];
  logic [MAG_W-1:0]   rem_in  [DIV_STAGES];
  logic [RATIO_W-1:0] bits_in [DIV_STAGES];
  logic [RATIO_W-1:0] quo_in  [DIV_STAGES];
  logic [MAG_W-1:0]   hi_in   [DIV_STAGES];
  side_t              side_in [DIV_STAGES];
  logic [MAG_W-1:0]   rem_d   [DIV_STAGES];
  logic [RATIO_W-1:0] bits_d  [DIV_STAGES];
  logic [RATIO_W-1:0] quo_d   [DIV_STAGES];

  // Route each stage's input from the previous stage or from the ports.
  always_comb begin
    vld_in[0]  = valid_i;
    rem_in[0]  = {1'b0, num_i[NUM_W-1:RATIO_W]};
    bits_in[0] = num_i[RATIO_W-1:0];
    quo_in[0]  = '0;
    hi_in[0]   = hi_i;
    side_in[0] = side_i;
    for (int g = 1; g < DIV_STAGES; g++) begin
      vld_in[g]  = vld_q[g-1];
      rem_in[g]  = rem_q[g-1];
      bits_in[g] = bits_q[g-1];
      quo_in[g]  = quo_q[g-1];
      hi_in[g]   = hi_q[g-1];
      side_in[g] = side_q[g-1];
    end
  end

  // Compare-and-subtract steps of every stage; the remainder stays below hi.
  always_comb begin
    logic [MAG_W-1:0]   rem;
    logic [MAG_W:0]     trial;
    logic [RATIO_W-1:0] bits;
    logic [RATIO_W-1:0] quo;
    logic               qbit;
    for (int g = 0; g < DIV_STAGES; g++) begin
      rem  = rem_in[g];
      bits = bits_in[g];
      quo  = quo_in[g];
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        if (g * DIV_STEPS_PER_STAGE + k < RATIO_W) begin
          trial = {rem, bits[RATIO_W-1]};
          bits  = bits << 1;
          qbit  = trial >= {1'b0, hi_in[g]};
          if (qbit) begin
            trial = trial - {1'b0, hi_in[g]};
          end
          rem = trial[MAG_W-1:0];
          quo = {quo[RATIO_W-2:0], qbit};
        end
      end
      rem_d[g]  = rem;
      bits_d[g] = bits;
      quo_d[g]  = quo;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < DIV_STAGES; g++) begin
        vld_q[g] <= 1'b0;
      end
    end else if (adv_i) begin
      for (int g = 0; g < DIV_STAGES; g++) begin
        vld_q[g] <= vld_in[g];
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int g = 0; g < DIV_STAGES; g++) begin
        rem_q[g]  <= rem_d[g];
        bits_q[g] <= bits_d[g];
        quo_q[g]  <= quo_d[g];
        hi_q[g]   <= hi_in[g];
        side_q[g] <= side_in[g];
      end
    end
  end

  // The ratio never exceeds one; clamp anyway to keep the format closed.
  assign valid_o = vld_q[DIV_STAGES-1];
  assign ratio_o = (quo_q[DIV_STAGES-1] > RATIO_ONE) ? RATIO_ONE : quo_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

FILE: sv/atan2_poly.sv
// ----------------------------------------------------------------------------
// atan2_poly: arctangent polynomial on the first octant
// Evaluates a + a*s*(c1 + s*(c2 + s*c3)) with s = a*a at 30 fraction bits,
// alternating one multiply stage with one rounding and accumulate stage.
// ----------------------------------------------------------------------------
module atan2_poly
  import atan2_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [RATIO_W-1:0]    ratio_i,
  input  side_t                 side_i,
  output logic                  valid_o,
  output logic signed [T_W-1:0] t_o,
  output side_t                 side_o
);

  logic  vld_q  [POLY_STAGES];
  side_t side_q [POLY_STAGES];

  logic        [SQ_W-1:0]    sq1_q;
  logic        [RATIO_W-1:0] a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, a7_q, a8_q, a9_q;
  logic        [RATIO_W-1:0] s2_q, s3_q, s4_q, s5_q, s6_q;
  logic signed [M3_W-1:0]    m3_q;
  logic signed [P_W-1:0]     p4_q;
  logic signed [M5_W-1:0]    m5_q;
  logic signed [Q_W-1:0]     q6_q;
  logic signed [M7_W-1:0]    m7_q;
  logic signed [R_W-1:0]     r8_q;
  logic signed [M9_W-1:0]    m9_q;
  logic signed [T_W-1:0]     t10_q;

  logic        [SQ_W-1:0]    sq_rnd;
  logic signed [M3_W-1:0]    m3_rnd;
  logic signed [M5_W-1:0]    m5_rnd;
  logic signed [M7_W-1:0]    m7_rnd;
  logic signed [M9_W-1:0]    m9_rnd;

  // Rounding adds, half away from zero, before each shift by 16.
  always_comb begin
    sq_rnd = sq1_q + SQ_W'(HALF_LSB);
    m3_rnd = m3_q + (m3_q[M3_W-1] ? M3_W'(HALF_LSB - 1) : M3_W'(HALF_LSB));
    m5_rnd = m5_q + (m5_q[M5_W-1] ? M5_W'(HALF_LSB - 1) : M5_W'(HALF_LSB));
    m7_rnd = m7_q + (m7_q[M7_W-1] ? M7_W'(HALF_LSB - 1) : M7_W'(HALF_LSB));
    m9_rnd = m9_q + (m9_q[M9_W-1] ? M9_W'(HALF_LSB - 1) : M9_W'(HALF_LSB));
  end

  // Valid and sideband shift along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POLY_STAGES; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < POLY_STAGES; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < POLY_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
      // Square of the ratio.
      sq1_q <= SQ_W'(ratio_i) * SQ_W'(ratio_i);
      a1_q  <= ratio_i;
      // s = a*a in Q0.16.
      s2_q  <= sq_rnd[FRAC_W +: RATIO_W];
      a2_q  <= a1_q;
      // c3 * s.
      m3_q  <= COEF_C3 * $signed({1'b0, s2_q});
      s3_q  <= s2_q;
      a3_q  <= a2_q;
      // p = c2 + c3*s.
      p4_q  <= $signed(m3_rnd[FRAC_W +: P_W]) + COEF_C2;
      s4_q  <= s3_q;
      a4_q  <= a3_q;
      // p * s.
      m5_q  <= p4_q * $signed({1'b0, s4_q});
      s5_q  <= s4_q;
      a5_q  <= a4_q;
      // q = c1 + p*s.
      q6_q  <= $signed(m5_rnd[FRAC_W +: Q_W]) + COEF_C1;
      s6_q  <= s5_q;
      a6_q  <= a5_q;
      // q * s.
      m7_q  <= q6_q * $signed({1'b0, s6_q});
      a7_q  <= a6_q;
      // r = q*s.
      r8_q  <= $signed(m7_rnd[FRAC_W +: R_W]);
      a8_q  <= a7_q;
      // r * a.
      m9_q  <= r8_q * $signed({1'b0, a8_q});
      a9_q  <= a8_q;
      // t = a + r*a at 30 fraction bits.
      t10_q <= $signed({1'b0, a9_q, {Q30_SHIFT{1'b0}}}) + $signed(m9_rnd[FRAC_W +: T_W]);
    end
  end

  assign valid_o = vld_q[POLY_STAGES-1];
  assign t_o     = t10_q;
  assign side_o  = side_q[POLY_STAGES-1];

endmodule

FILE: sv/atan2_fold.sv
// ----------------------------------------------------------------------------
// atan2_fold: octant folding, rounding and saturation
// Maps the first-octant angle to the full circle with one add, then rounds
// to the output format, clamps to plus or minus pi and holds the result.
// ----------------------------------------------------------------------------
module atan2_fold
  import atan2_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [T_W-1:0]         t_i,
  input  side_t                         side_i,
  output logic                          valid_o,
  output logic signed [ANGLE_WIDTH-1:0] angle_o
);

  localparam logic signed [FOLD_W-1:0] HALF_A = FOLD_W'(1 << (ANGLE_SHIFT - 1));

  logic                      vld_q;
  logic                      zero_q;
  logic signed [FOLD_W-1:0]  v_q;
  logic signed [FOLD_W-1:0]  v_d;
  logic signed [FOLD_W-1:0]  te;
  logic signed [FOLD_W-1:0]  base;
  logic                      neg_t;
  logic signed [FOLD_W-1:0]  rnd;
  logic signed [FOLD_W-1:0]  ang;
  logic signed [ANGLE_WIDTH-1:0] angle_d;

  // Fold: the three conditional steps reduce to +-K +- t.
  always_comb begin
    te    = FOLD_W'(t_i);
    neg_t = side_i.swap ^ side_i.xneg;
    if (side_i.swap) begin
      base = HALF_PI;
    end else if (side_i.xneg) begin
      base = PI;
    end else begin
      base = '0;
    end
    if (side_i.yneg) begin
      base  = -base;
      neg_t = ~neg_t;
    end
    v_d = base + (neg_t ? ~te : te) + $signed({{(FOLD_W-1){1'b0}}, neg_t});
  end

  // Round half away from zero, clamp, and force the origin to zero.
  always_comb begin
    rnd = v_q + (v_q[FOLD_W-1] ? (HALF_A - FOLD_W'(1)) : HALF_A);
    ang = rnd >>> ANGLE_SHIFT;
    if (ang > ANGLE_LIMIT) begin
      ang = ANGLE_LIMIT;
    end else if (ang < -ANGLE_LIMIT) begin
      ang = -ANGLE_LIMIT;
    end
    angle_d = zero_q ? '0 : $signed(ang[ANGLE_WIDTH-1:0]);
  end

  // Valid bits of the fold stage and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      vld_q   <= valid_i;
      valid_o <= vld_q;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      v_q     <= v_d;
      zero_q  <= side_i.zero;
      angle_o <= angle_d;
    end
  end

endmodule

FILE: sv/two_argument_arctangent.sv
// ----------------------------------------------------------------------------
// two_argument_arctangent: pipelined atan2 in signed Q2.13
//
// Accepts one (x, y) pair in every clock cycle while in_ready_o is high and
// returns its angle in radians, signed Q2.13, clamped to plus or minus 25736.
// The result passes the prep register, the ratio divider, which resolves its
// 17 quotient bits two per stage (one in the last) over nine stages, the ten
// stages of the polynomial, where each of the five multiplications is
// followed by its own rounding stage, and the fold and output registers.
// When the output register holds a result that is not taken, the whole
// pipeline holds and in_ready_o drops; otherwise in_ready_o is high.
// ----------------------------------------------------------------------------
module two_argument_arctangent
  import atan2_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [INPUT_WIDTH-1:0] x_coord_i,
  input  logic signed [INPUT_WIDTH-1:0] y_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ANGLE_WIDTH-1:0] angle_o
);

  logic               adv;
  logic               prep_vld, div_vld, poly_vld;
  logic [NUM_W-1:0]   prep_num;
  logic [MAG_W-1:0]   prep_hi;
  side_t              prep_side, div_side, poly_side;
  logic [RATIO_W-1:0] div_ratio;
  logic signed [T_W-1:0] poly_t;

  // The pipeline moves whenever the output register is free or being read.
  assign adv        = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;

  atan2_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (in_valid_i),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .valid_o   (prep_vld),
    .num_o     (prep_num),
    .hi_o      (prep_hi),
    .side_o    (prep_side)
  );

  atan2_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (prep_vld),
    .num_i   (prep_num),
    .hi_i    (prep_hi),
    .side_i  (prep_side),
    .valid_o (div_vld),
    .ratio_o (div_ratio),
    .side_o  (div_side)
  );

  atan2_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_vld),
    .ratio_i (div_ratio),
    .side_i  (div_side),
    .valid_o (poly_vld),
    .t_o     (poly_t),
    .side_o  (poly_side)
  );

  atan2_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (poly_vld),
    .t_i     (poly_t),
    .side_i  (poly_side),
    .valid_o (out_valid_o),
    .angle_o (angle_o)
  );

endmodule

FILE: sv/atan2_checker.sv
// ----------------------------------------------------------------------------
// atan2_checker: port-level checks of the arctangent block
// Watches the handshakes and the result range at the top-level ports.
// ----------------------------------------------------------------------------
module atan2_checker
  import atan2_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_o
);

  // A stalled result stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_o))
    else $error("stalled result changed or dropped");

  // With an empty output register the block always takes a transaction.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output is empty");

  // While the output is stalled the pipeline holds and takes nothing.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !(in_valid_i && in_ready_o))
    else $error("transaction accepted while pipeline is stalled");

  // Every result lies within plus or minus pi.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(angle_o) <= ANGLE_LIMIT) && ($signed(angle_o) >= -ANGLE_LIMIT))
    else $error("angle outside the clamp range");

endmodule

bind two_argument_arctangent atan2_checker u_atan2_checker (.*);

FILE: test/two_argument_arctangent_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_argument_arctangent_tb: self-checking bench for the atan2 pipeline
// A queue-fed driver offers coordinate pairs, and an in-bench fixed-point
// model predicts each angle. A monitor checks every returned angle in order
// through directed corners, random pairs under several idling mixes, and a
// long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module two_argument_arctangent_tb;
  import atan2_pkg::*;

  // Polynomial coefficients of the arctangent approximation, at 30 fraction bits.
  localparam longint POLY_C1_Q30 = -64'sd351782264;
  localparam longint POLY_C2_Q30 = 64'sd171062341;
  localparam longint POLY_C3_Q30 = -64'sd49925210;

  localparam int HOLD_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct packed {
    logic signed [INPUT_WIDTH-1:0] x;
    logic signed [INPUT_WIDTH-1:0] y;
  } coord_pair_t;

  typedef struct packed {
    coord_pair_t                   pair;
    logic signed [ANGLE_WIDTH-1:0] angle;
  } angle_entry_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic signed [INPUT_WIDTH-1:0] x_coord_i   = '0;
  logic signed [INPUT_WIDTH-1:0] y_coord_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [ANGLE_WIDTH-1:0] angle_o;

  coord_pair_t  pending_pairs[$];
  angle_entry_t angle_expected[$];
  angle_entry_t oldest_angle;

  int  send_idle_pct   = 0;
  int  recv_stall_pct  = 0;
  int  pairs_offered   = 0;
  int  pairs_accepted  = 0;
  int  angles_checked  = 0;
  int  mismatch_count  = 0;
  int  quiet_cycles    = 0;
  int  hold_left       = 0;
  bit  hold_req        = 1'b0;
  bit  hold_ack        = 1'b0;

  two_argument_arctangent DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .angle_o    (angle_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shift right with rounding half away from zero.
  function automatic longint round_shr(longint v, int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // Predicts the Q2.13 angle of one coordinate pair.
  function automatic logic signed [ANGLE_WIDTH-1:0] predict_angle(
    logic signed [INPUT_WIDTH-1:0] x, logic signed [INPUT_WIDTH-1:0] y);
    longint mag_x, mag_y, lo, hi, ratio, sq, p, q, r, t, ang, limit;
    mag_x = (x < 0) ? -longint'(x) : longint'(x);
    mag_y = (y < 0) ? -longint'(y) : longint'(y);
    if (mag_x == 0 && mag_y == 0) return '0;
    if (mag_x > mag_y) begin
      lo = mag_y;
      hi = mag_x;
    end else begin
      lo = mag_x;
      hi = mag_y;
    end
    ratio = ((lo <<< 16) + (hi >>> 1)) / hi;
    if (ratio > 65536) ratio = 65536;
    sq = (ratio * ratio + 32768) >>> 16;
    // Horner evaluation of the odd polynomial at 30 fraction bits.
    p = POLY_C2_Q30 + round_shr(POLY_C3_Q30 * sq, 16);
    q = POLY_C1_Q30 + round_shr(p * sq, 16);
    r = round_shr(q * sq, 16);
    t = (ratio <<< 14) + round_shr(r * ratio, 16);
    // Fold the first-octant angle back into the full circle.
    if (mag_y > mag_x) t = HALF_PI_Q30 - t;
    if (x < 0) t = PI_Q30 - t;
    if (y < 0) t = -t;
    ang = round_shr(t, 30 - ANGLE_FRACTION_BITS);
    limit = round_shr(PI_Q30, 30 - ANGLE_FRACTION_BITS);
    if (limit > (longint'(1) <<< (ANGLE_WIDTH - 1)) - 1)
      limit = (longint'(1) <<< (ANGLE_WIDTH - 1)) - 1;
    if (ang > limit) ang = limit;
    if (ang < -limit) ang = -limit;
    return ANGLE_WIDTH'(ang);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_pair(input int x, input int y);
    coord_pair_t pair;
    pair.x = INPUT_WIDTH'(x);
    pair.y = INPUT_WIDTH'(y);
    pending_pairs.push_back(pair);
  endtask

  function automatic int corner_value(int k);
    case (k)
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  // Random pairs, weighted toward the interesting regions of the angle.
  task automatic push_random_pairs(input int count);
    int x, y, m;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        4: begin
          // Nearly equal magnitudes, where the ratio may round to one.
          m = $urandom_range(16384, 32767);
          x = m;
          y = m - $urandom_range(0, 3);
          if ($urandom_range(1)) x = -x;
          if ($urandom_range(1)) y = -y;
        end
        5: begin
          // On an axis.
          x = $urandom_range(65535) - 32768;
          y = 0;
          if ($urandom_range(1)) begin
            y = x;
            x = 0;
          end
        end
        6: begin
          x = $urandom_range(6) - 3;
          y = $urandom_range(6) - 3;
        end
        7: begin
          x = corner_value($urandom_range(5));
          y = corner_value($urandom_range(5));
        end
        8: begin
          // Very small ratio, in either orientation.
          x = $urandom_range(65535) - 32768;
          y = $urandom_range(16) - 8;
          if ($urandom_range(1)) begin
            m = x;
            x = y;
            y = m;
          end
        end
        default: begin
          x = $urandom;
          y = $urandom;
        end
      endcase
      push_pair(x, y);
    end
  endtask

  // Blocks until every queued pair has gone in and every angle has come out.
  task automatic wait_for_drain();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || in_valid_i || angle_expected.size() != 0);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Driver: offers the next pending pair once the previous one was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || pairs_accepted == pairs_offered) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        x_coord_i     <= pending_pairs[0].x;
        y_coord_i     <= pending_pairs[0].y;
        in_valid_i    <= 1'b1;
        pairs_offered <= pairs_offered + 1;
        void'(pending_pairs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long output hold-off, started by toggling hold_req.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver readiness.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transaction, checks each output transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        angle_expected.push_back({x_coord_i, y_coord_i, predict_angle(x_coord_i, y_coord_i)});
        pairs_accepted <= pairs_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (angle_expected.size() == 0) begin
          report_mismatch($sformatf("angle %0d arrived with no pair outstanding", angle_o));
        end else begin
          oldest_angle = angle_expected.pop_front();
          angles_checked++;
          if (angle_o !== oldest_angle.angle)
            report_mismatch($sformatf("x=%0d y=%0d: angle %0d, expected %0d",
                                      oldest_angle.pair.x, oldest_angle.pair.y,
                                      angle_o, oldest_angle.angle));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: origin, axes, equal magnitudes, extremes and near-pi.
    set_idling(0, 0);
    push_pair(0, 0);
    push_pair(32767, 0);
    push_pair(-32768, 0);
    push_pair(-1, 0);
    push_pair(1, 0);
    push_pair(0, 32767);
    push_pair(0, -32768);
    push_pair(0, 1);
    push_pair(0, -1);
    push_pair(32767, 32767);
    push_pair(-32768, -32768);
    push_pair(32767, -32768);
    push_pair(-32768, 32767);
    push_pair(1, 1);
    push_pair(-1, 1);
    push_pair(1, -1);
    push_pair(-1, -1);
    push_pair(32767, 32766);
    push_pair(-32766, 32767);
    push_pair(-32768, -1);
    push_pair(-32768, 1);
    push_pair(-1, -32768);
    push_pair(32767, 1);
    push_pair(12345, -23456);
    wait_for_drain();

    push_random_pairs(200);
    wait_for_drain();

    set_idling(73, 0);
    push_random_pairs(150);
    wait_for_drain();

    set_idling(0, 73);
    push_random_pairs(150);
    wait_for_drain();

    set_idling(13, 13);
    push_random_pairs(150);
    wait_for_drain();

    // Output held off while the sender keeps offering, so the pipeline backs up.
    set_idling(0, 0);
    hold_req = ~hold_req;
    push_random_pairs(150);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d angles from %0d coordinate pairs (%0d mismatches).",
             angles_checked, pairs_accepted, mismatch_count);
    $display("Covered axis, origin and equal-magnitude corners, random pairs under %s",
             "free flow, sparse input, heavy and mixed stalls, and a long hold-off.");
    if (mismatch_count == 0 && angle_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (angle_expected.size() != 0)
        $display("%0d expected angles never arrived", angle_expected.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/atan2_pkg.sv
sv/atan2_prep.sv
sv/atan2_div.sv
sv/atan2_poly.sv
sv/atan2_fold.sv
sv/two_argument_arctangent.sv
sv/atan2_checker.sv
test/two_argument_arctangent_tb.sv
